>>> rtl/core/zfl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the zone free-list allocator.
// No dependencies; every other file in rtl/core imports this package.
package zfl_pkg;

   // sizing
   localparam int STACK_DEPTH = 4096;
   localparam int PAGE_BYTES  = 4096;
   localparam int ADDR_BITS   = 32;
   localparam int SP_BITS     = $clog2(STACK_DEPTH);
   localparam int CNT_BITS    = SP_BITS + 1;
   localparam int SIZE_BITS   = 13;
   localparam int OFS_BITS    = $clog2(PAGE_BYTES) + 2;
   localparam int ISSUE_BITS  = 32;

   // object size limits and reset value
   localparam logic [SIZE_BITS-1:0] OBJ_SIZE_MIN   = SIZE_BITS'(4);
   localparam logic [SIZE_BITS-1:0] OBJ_SIZE_MAX   = SIZE_BITS'(4096);
   localparam logic [SIZE_BITS-1:0] OBJ_SIZE_RESET = SIZE_BITS'(64);

   // request codes
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_OOM  = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   typedef struct packed {
      logic                 req_type;
      logic [ADDR_BITS-1:0] free_addr;
      logic [ADDR_BITS-1:0] page_base;
      logic                 page_ok;
   } req_beat_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  alloc_addr;
      logic [1:0]            status;
      logic                  page_taken;
      logic [CNT_BITS-1:0]   free_items;
      logic [ISSUE_BITS-1:0] issued_items;
   } rsp_beat_type;

   // sequencer to carve unit
   typedef struct packed {
      logic load;
      logic step;
   } carve_cmd_type;

   // carve unit to sequencer
   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic                 fits;
   } carve_sts_type;

endpackage

>>> rtl/core/zfl_stack_mem.sv
`timescale 1ns / 1ps
// Free-address stack storage: one write port, one registered read port.
// Depends on zfl_pkg for depth and address width.
module zfl_stack_mem (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [zfl_pkg::SP_BITS-1:0]   wr_addr,
   input  logic [zfl_pkg::ADDR_BITS-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [zfl_pkg::SP_BITS-1:0]   rd_addr,
   output logic [zfl_pkg::ADDR_BITS-1:0] rd_data
);
   import zfl_pkg::*;

   logic [ADDR_BITS-1:0] mem [STACK_DEPTH];
   logic [ADDR_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/zfl_carve_unit.sv
`timescale 1ns / 1ps
// Page carving datapath: two adders step the object address and the page
// offset by the object size. Depends on zfl_pkg.
module zfl_carve_unit (
   input  logic                          clock,
   input  zfl_pkg::carve_cmd_type        cmd,
   input  logic [zfl_pkg::ADDR_BITS-1:0] page_base,
   input  logic [zfl_pkg::SIZE_BITS-1:0] object_size,
   output zfl_pkg::carve_sts_type        sts
);
   import zfl_pkg::*;

   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [OFS_BITS-1:0]  ofs_ff, ofs_in;
   logic [SIZE_BITS-1:0] size_clamped;
   logic [OFS_BITS-1:0]  ofs_sum;

   // clamp object size to the legal range
   always_comb begin
      if (object_size < OBJ_SIZE_MIN) begin
         size_clamped = OBJ_SIZE_MIN;
      end else if (object_size > OBJ_SIZE_MAX) begin
         size_clamped = OBJ_SIZE_MAX;
      end else begin
         size_clamped = object_size;
      end
   end

   // end of the current object within the page
   assign ofs_sum = ofs_ff + OFS_BITS'(size_clamped);

   // next address and offset
   always_comb begin
      addr_in = addr_ff;
      ofs_in  = ofs_ff;
      if (cmd.load) begin
         addr_in = page_base;
         ofs_in  = '0;
      end else if (cmd.step) begin
         addr_in = addr_ff + ADDR_BITS'(size_clamped);
         ofs_in  = ofs_sum;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      ofs_ff  <= ofs_in;
   end

   assign sts.addr = addr_ff;
   assign sts.fits = (ofs_sum <= OFS_BITS'(PAGE_BYTES));

endmodule

>>> rtl/core/zfl_ctrl.sv
`timescale 1ns / 1ps
// Allocator sequencer: request decode, stack pointer, counters, carve loop
// and the response register. Depends on zfl_pkg, drives zfl_stack_mem and
// zfl_carve_unit.
module zfl_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  zfl_pkg::req_beat_type         req_beat,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output zfl_pkg::rsp_beat_type         rsp_beat,
   output logic                          mem_wr_en,
   output logic [zfl_pkg::SP_BITS-1:0]   mem_wr_addr,
   output logic [zfl_pkg::ADDR_BITS-1:0] mem_wr_data,
   output logic                          mem_rd_en,
   output logic [zfl_pkg::SP_BITS-1:0]   mem_rd_addr,
   input  logic [zfl_pkg::ADDR_BITS-1:0] mem_rd_data,
   output zfl_pkg::carve_cmd_type        carve_cmd,
   input  zfl_pkg::carve_sts_type        carve_sts
);
   import zfl_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CARVE,
      ST_READ,
      ST_DONE
   } state_type;

   localparam logic [CNT_BITS-1:0] STACK_FULL = CNT_BITS'(STACK_DEPTH);

   state_type             state_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic [ISSUE_BITS-1:0] issued_ff;
   logic [31:0]           carved_ff;
   logic [ADDR_BITS-1:0]  addr_ff;
   logic [1:0]            status_ff;
   logic                  taken_ff;
   logic                  rsp_valid_ff;
   rsp_beat_type          rsp_beat_ff;

   logic                  accept;
   logic                  slot_free;
   logic                  rsp_load;
   logic                  is_full;
   logic                  is_empty;
   logic                  carve_push;
   logic [CNT_BITS-1:0]   count_dec;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load   = (state_ff == ST_DONE) && slot_free;
   assign is_full    = (count_ff == STACK_FULL);
   assign is_empty   = (count_ff == '0);
   assign count_dec  = count_ff - CNT_BITS'(1);
   assign carve_push = carve_sts.fits && !is_full;

   // stack port and carve unit control
   always_comb begin
      mem_wr_en      = 1'b0;
      mem_wr_addr    = count_ff[SP_BITS-1:0];
      mem_wr_data    = req_beat.free_addr;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = count_dec[SP_BITS-1:0];
      carve_cmd.load = 1'b0;
      carve_cmd.step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_beat.req_type == REQ_FREE) begin
                  mem_wr_en = !is_full;
               end else if (is_empty) begin
                  carve_cmd.load = req_beat.page_ok;
               end else begin
                  mem_rd_en = 1'b1;
               end
            end
         end
         ST_CARVE: begin
            if (carve_push) begin
               mem_wr_en      = 1'b1;
               mem_wr_data    = carve_sts.addr;
               carve_cmd.step = 1'b1;
            end else begin
               mem_rd_en = 1'b1;
            end
         end
         ST_READ: begin
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // sequencer state, counters and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issued_ff    <= '0;
         carved_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  addr_ff   <= '0;
                  status_ff <= STAT_OK;
                  taken_ff  <= 1'b0;
                  if (req_beat.req_type == REQ_FREE) begin
                     if (is_full) begin
                        status_ff <= STAT_FULL;
                     end else begin
                        count_ff <= count_ff + CNT_BITS'(1);
                        if (issued_ff != '0) begin
                           issued_ff <= issued_ff - ISSUE_BITS'(1);
                        end
                     end
                     state_ff <= ST_DONE;
                  end else if (is_empty && req_beat.page_ok) begin
                     taken_ff <= 1'b1;
                     state_ff <= ST_CARVE;
                  end else if (is_empty) begin
                     status_ff <= STAT_OOM;
                     state_ff  <= ST_DONE;
                  end else begin
                     count_ff <= count_dec;
                     state_ff <= ST_READ;
                  end
               end
            end
            // one object pushed per cycle until the page or stack runs out
            ST_CARVE: begin
               if (carve_push) begin
                  count_ff <= count_ff + CNT_BITS'(1);
                  if (carved_ff != '1) begin
                     carved_ff <= carved_ff + 32'd1;
                  end
               end else begin
                  count_ff <= count_dec;
                  state_ff <= ST_READ;
               end
            end
            // popped address arrives from the stack
            ST_READ: begin
               addr_ff <= mem_rd_data;
               if (issued_ff != '1) begin
                  issued_ff <= issued_ff + ISSUE_BITS'(1);
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (slot_free) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_beat_ff.alloc_addr   <= addr_ff;
                  rsp_beat_ff.status       <= status_ff;
                  rsp_beat_ff.page_taken   <= taken_ff;
                  rsp_beat_ff.free_items   <= count_ff;
                  rsp_beat_ff.issued_items <= issued_ff;
                  state_ff                 <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

>>> rtl/core/zone_free_list_allocator_unit.sv
`timescale 1ns / 1ps
// Zone free-list allocator: fixed-size object allocator over a LIFO stack of
// free addresses (4096 entries). Depends on zfl_pkg, zfl_stack_mem,
// zfl_carve_unit and zfl_ctrl.
//
// Request channel (req_valid/req_ready/req_beat): one beat is an allocate or
// a free. Response channel (rsp_valid/rsp_ready/rsp_beat): exactly one beat
// per request, in request order. The object size register is written through
// csr_wr_en/csr_wr_data and resets to 64; the user must write it only while
// no request is in flight, which the block itself does not enforce. A free
// goes from the idle state to the done state, where its response is loaded;
// an allocate that pops passes the read state between them. An allocate into
// an empty stack with a page offered first carves the page through the address
// and offset adders, one object per cycle, with the size clamped to 4..4096.
// The next request can be taken in the cycle after the response is loaded.
// req_ready is high only while the sequencer is idle, and a new request may
// be accepted while the previous response still waits in the output register.
// If the receiver stalls, the next finished response is held until that
// register frees up. Reset clears the stack pointer and counters; no clearing
// pass is needed.
module zone_free_list_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  zfl_pkg::req_beat_type         req_beat,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output zfl_pkg::rsp_beat_type         rsp_beat,
   input  logic                          csr_wr_en,
   input  logic [zfl_pkg::SIZE_BITS-1:0] csr_wr_data
);
   import zfl_pkg::*;

   logic [SIZE_BITS-1:0] object_size_ff;
   logic                 mem_wr_en;
   logic [SP_BITS-1:0]   mem_wr_addr;
   logic [ADDR_BITS-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [SP_BITS-1:0]   mem_rd_addr;
   logic [ADDR_BITS-1:0] mem_rd_data;
   carve_cmd_type        carve_cmd;
   carve_sts_type        carve_sts;

   // object size register
   always_ff @(posedge clock) begin
      if (reset) begin
         object_size_ff <= OBJ_SIZE_RESET;
      end else if (csr_wr_en) begin
         object_size_ff <= csr_wr_data;
      end
   end

   zfl_stack_mem u_stack (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   zfl_carve_unit u_carve (
      .clock       (clock),
      .cmd         (carve_cmd),
      .page_base   (req_beat.page_base),
      .object_size (object_size_ff),
      .sts         (carve_sts)
   );

   zfl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_beat    (req_beat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_beat    (rsp_beat),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .carve_cmd   (carve_cmd),
      .carve_sts   (carve_sts)
   );

endmodule

>>> tb/sv/zfl_alloc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the zone free-list allocator: keeps a shadow stack and counters,
// predicts every response beat and compares it field by field. Depends on zfl_pkg.
module zfl_alloc_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  zfl_pkg::req_beat_type          req_beat,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  zfl_pkg::rsp_beat_type          rsp_beat,
   input  logic                           csr_wr_en,
   input  logic [zfl_pkg::SIZE_BITS-1:0]  csr_wr_data,
   output int                             open_count,
   output int                             fail_count,
   output int                             rsp_seen,
   output int                             oom_seen,
   output int                             full_seen,
   output int                             carve_seen,
   output logic [zfl_pkg::CNT_BITS-1:0]   stack_level
);
   import zfl_pkg::*;

   // shadow copy of the allocator state
   logic [ADDR_BITS-1:0]  shadow_stack [STACK_DEPTH];
   logic [CNT_BITS-1:0]   shadow_count;
   logic [ISSUE_BITS-1:0] shadow_issued;
   logic [SIZE_BITS-1:0]  shadow_size;
   rsp_beat_type          awaited_rsp [$];
   int                    fails, n_rsp, n_oom, n_full, n_carve;

   // push one address, refused when the stack is full
   function automatic bit stack_push(input logic [ADDR_BITS-1:0] a);
      if (shadow_count >= CNT_BITS'(STACK_DEPTH)) return 1'b0;
      shadow_stack[shadow_count[SP_BITS-1:0]] = a;
      shadow_count = shadow_count + 1'b1;
      return 1'b1;
   endfunction

   // apply one request to the shadow state and build the response beat
   function automatic rsp_beat_type serve_request(input req_beat_type r);
      rsp_beat_type         ans;
      logic [SIZE_BITS-1:0] sz;
      int unsigned          n_obj;
      ans = '0;
      if (r.req_type == REQ_FREE) begin
         if (stack_push(r.free_addr)) begin
            if (shadow_issued != '0) shadow_issued = shadow_issued - 1'b1;
         end else begin
            ans.status = STAT_FULL;
         end
      end else begin
         // empty stack with a page on offer: carve the page first
         if (shadow_count == '0 && r.page_ok) begin
            sz = shadow_size;
            if (sz < OBJ_SIZE_MIN) sz = OBJ_SIZE_MIN;
            if (sz > OBJ_SIZE_MAX) sz = OBJ_SIZE_MAX;
            n_obj = PAGE_BYTES / sz;
            if (n_obj > 0) begin
               ans.page_taken = 1'b1;
               for (int i = 0; i < n_obj; i++) begin
                  if (!stack_push(r.page_base + ADDR_BITS'(i * sz))) break;
               end
            end
         end
         if (shadow_count == '0) begin
            ans.status = STAT_OOM;
         end else begin
            shadow_count = shadow_count - 1'b1;
            ans.alloc_addr = shadow_stack[shadow_count[SP_BITS-1:0]];
            if (shadow_issued != '1) shadow_issued = shadow_issued + 1'b1;
         end
      end
      ans.free_items   = shadow_count;
      ans.issued_items = shadow_issued;
      return ans;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         fails++;
         $display("%0t mismatch on %s: expected %h, got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : track
      rsp_beat_type want;
      if (reset) begin
         shadow_count  = '0;
         shadow_issued = '0;
         shadow_size   = OBJ_SIZE_RESET;
         awaited_rsp.delete();
      end else begin
         if (csr_wr_en) shadow_size = csr_wr_data;
         // response beat against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               fails++;
               $display("%0t response beat with none awaited: got %h", $time, rsp_beat);
            end else begin
               want = awaited_rsp.pop_front();
               n_rsp++;
               if (want.status == STAT_OOM) n_oom++;
               if (want.status == STAT_FULL) n_full++;
               if (want.page_taken) n_carve++;
               check_field("alloc_addr", want.alloc_addr, rsp_beat.alloc_addr);
               check_field("status", want.status, rsp_beat.status);
               check_field("page_taken", want.page_taken, rsp_beat.page_taken);
               check_field("free_items", want.free_items, rsp_beat.free_items);
               check_field("issued_items", want.issued_items, rsp_beat.issued_items);
            end
         end
         // request beat: predict its response
         if (req_valid && req_ready) awaited_rsp.push_back(serve_request(req_beat));
      end
      open_count  <= awaited_rsp.size();
      fail_count  <= fails;
      rsp_seen    <= n_rsp;
      oom_seen    <= n_oom;
      full_seen   <= n_full;
      carve_seen  <= n_carve;
      stack_level <= shadow_count;
   end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the free-list allocator testbench: clock, reset, request and response stimulus,
// object size writes and the verdict. Depends on zfl_pkg, zfl_alloc_checker, zone_free_list_allocator_unit.
module tb_top;
   import zfl_pkg::*;

   localparam int PHASE_ITEMS = 115;
   localparam int CALM_ITEMS  = 70;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_LIMIT = 20000;

   logic                 clock, reset;
   logic                 req_valid, req_ready, rsp_valid, rsp_ready, csr_wr_en;
   req_beat_type         req_beat;
   rsp_beat_type         rsp_beat;
   logic [SIZE_BITS-1:0] csr_wr_data;
   int                   open_count, fail_count, rsp_seen, oom_seen, full_seen, carve_seen;
   logic [CNT_BITS-1:0]  stack_level;
   logic                 calm, hold_ask;
   bit                   hold_served, gappy;
   int                   size_plan [12] = '{4096, 8191, 2048, 0, 4097, 3, 100, -1, 4, 1024,
                                            37, -1};

   zone_free_list_allocator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_beat    (req_beat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_beat    (rsp_beat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   zfl_alloc_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_beat    (req_beat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_beat    (rsp_beat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .open_count  (open_count),
      .fail_count  (fail_count),
      .rsp_seen    (rsp_seen),
      .oom_seen    (oom_seen),
      .full_seen   (full_seen),
      .carve_seen  (carve_seen),
      .stack_level (stack_level)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #100_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic req_beat_type make_req(input logic kind,
                                             input logic [ADDR_BITS-1:0] faddr, pbase,
                                             input logic pok);
      req_beat_type b;
      b.req_type  = kind;
      b.free_addr = faddr;
      b.page_base = pbase;
      b.page_ok   = pok;
      return b;
   endfunction

   // random request; half the pages are aligned, a quarter near the top of memory
   function automatic req_beat_type random_req(input int alloc_pct, input int page_pct);
      logic [ADDR_BITS-1:0] pbase;
      case ($urandom_range(0, 3))
         0: pbase = $urandom;
         1: pbase = 32'hFFFF_F000 | $urandom_range(0, 4095);
         default: pbase = $urandom & 32'hFFFF_F000;
      endcase
      return make_req(($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_FREE,
                      $urandom, pbase, $urandom_range(0, 99) < page_pct);
   endfunction

   // offer one request beat, with an optional gap before it
   task automatic offer(input req_beat_type b);
      if (!calm && gappy && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_beat  <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait until every response beat has come back or DRAIN_LIMIT runs out
   task automatic drain_responses();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic set_object_size(input logic [SIZE_BITS-1:0] v);
      drain_responses();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // response side: random stalls, quiet stretches, one long hold-off
   initial begin
      rsp_ready   <= 1'b0;
      hold_served = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!calm && hold_ask && !hold_served) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_served = 1'b1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   // request side and verdict
   initial begin
      int alloc_pct, sz;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_beat    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      calm        <= 1'b0;
      hold_ask    <= 1'b0;
      gappy       = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty stack, free with nothing issued, ignored page, wrapping carve
      offer(make_req(REQ_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
      offer(make_req(REQ_FREE, 32'hFFFF_FFFF, 32'hFFFF_F000, 1'b1));
      offer(make_req(REQ_ALLOC, 32'h0000_0000, 32'h1234_5000, 1'b1));
      offer(make_req(REQ_ALLOC, 32'hA5A5_A5A5, 32'hFFFF_FFF0, 1'b1));
      offer(make_req(REQ_FREE, 32'h0000_0000, 32'h0000_0000, 1'b0));
      offer(make_req(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
      offer(make_req(REQ_FREE, 32'h5A5A_5A5A, 32'h0000_0000, 1'b1));
      offer(make_req(REQ_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1));

      // random phases, one object size each
      foreach (size_plan[p]) begin
         sz = (size_plan[p] < 0) ? $urandom_range(5, 4095) : size_plan[p];
         set_object_size(SIZE_BITS'(sz));
         alloc_pct = $urandom_range(35, 85);
         if (p == 1) hold_ask <= 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 32 == 0) gappy = $urandom_range(0, 2) != 0;
            offer(random_req(alloc_pct, 75));
         end
      end

      // last part without any idling
      drain_responses();
      calm <= 1'b1;
      for (int k = 0; k < CALM_ITEMS; k++) offer(random_req(55, 75));

      drain_responses();
      repeat (20) @(posedge clock);
      $display("run covered %0d responses: %0d out of memory, %0d refused frees, %0d carves",
               rsp_seen, oom_seen, full_seen, carve_seen);
      $display("object sizes from 0 to 8191 written, %0d addresses left stacked, long stall",
               stack_level);
      if (fail_count == 0 && open_count == 0) begin
         $display("All tests passed");
      end else begin
         if (open_count != 0) $display("%0t %0d response beats never arrived", $time, open_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/zfl_pkg.sv
rtl/core/zfl_stack_mem.sv
rtl/core/zfl_carve_unit.sv
rtl/core/zfl_ctrl.sv
rtl/core/zone_free_list_allocator_unit.sv
tb/sv/zfl_alloc_checker.sv
tb/sv/tb_top.sv
